/* rtl/dmd_pkg.sv */
// dmd_pkg: shared types, constants and byte tables for the device message deframer
// no dependencies; used by every module in rtl/
package dmd_pkg;

	// framing bytes
	localparam logic [7:0] BYTE_SOF = 8'h02;
	localparam logic [7:0] BYTE_CR  = 8'h0D;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_ETX = 8'h03;

	// header and tail geometry, indexed by a 3-bit match counter
	localparam logic [2:0] HDR_LEN   = 3'd3;
	localparam logic [2:0] HDR_LAST  = 3'd2;
	localparam logic [2:0] TAIL_LEN  = 3'd5;
	localparam logic [2:0] TAIL_LAST = 3'd4;

	// header + size + type + devtype + serial + tail
	localparam logic [15:0] FRAME_OVERHEAD = 16'd13;
	localparam logic [15:0] MAX_FRAME_RESET = 16'd1024;

	typedef enum logic [3:0] {
		PH_HUNT    = 4'd0,
		PH_SIZE_HI = 4'd1,
		PH_SIZE_LO = 4'd2,
		PH_TYPE    = 4'd3,
		PH_DEVTYPE = 4'd4,
		PH_SERIAL  = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_TAIL    = 4'd7
	} phase_t;

	typedef enum logic [1:0] {
		ST_BUSY     = 2'd0,
		ST_GOOD     = 2'd1,
		ST_BAD_TAIL = 2'd2,
		ST_BAD_LEN  = 2'd3
	} status_t;

	// one word held in the input register
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} stage_t;

	// one result word
	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic [7:0]  message_type;
		logic [7:0]  device_type;
		logic [7:0]  device_serial;
		logic [15:0] payload_length;
		status_t     frame_status;
	} result_t;

	// expected header byte; callers keep idx below HDR_LEN
	function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = BYTE_SOF;
			3'd1:    b = BYTE_CR;
			default: b = BYTE_LF;
		endcase
		return b;
	endfunction

	// expected tail byte; callers keep idx below TAIL_LEN
	function automatic logic [7:0] tail_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = BYTE_CR;
			3'd1:    b = BYTE_LF;
			3'd2:    b = BYTE_ETX;
			3'd3:    b = BYTE_CR;
			default: b = BYTE_LF;
		endcase
		return b;
	endfunction

endpackage

/* rtl/dmd_in_stage.sv */
// dmd_in_stage: input register of the deframer with valid/stall handshake
// depends on dmd_pkg (stage_t)
module dmd_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      rx_byte,
	input  logic            advance,
	output dmd_pkg::stage_t item
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	// hold off the sender only while a word sits here and cannot move on
	assign in_stall = valid_s1 && !advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// data
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	assign item.valid = valid_s1;
	assign item.data  = byte_s1;

endmodule

/* rtl/dmd_parser.sv */
// dmd_parser: frame state machine and result register of the deframer
// depends on dmd_pkg (phase_t, status_t, stage_t, result_t, byte tables)
module dmd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  dmd_pkg::stage_t  item,
	input  logic [15:0]      max_frame_size,
	input  logic             out_stall,
	output logic             advance,
	output logic             out_valid,
	output dmd_pkg::result_t result
);

	dmd_pkg::phase_t  phase_q, phase_n;
	logic [2:0]       match_q, match_n;
	logic [15:0]      size_q, size_n;
	logic [15:0]      remain_q, remain_n;
	logic [7:0]       type_q, type_n;
	logic [7:0]       devtype_q, devtype_n;
	logic [7:0]       serial_q, serial_n;
	logic             terr_q, terr_n;

	logic             out_valid_s2;
	dmd_pkg::result_t result_s2;
	dmd_pkg::result_t result_n;

	logic             take;
	logic [7:0]       b;
	logic [15:0]      size_w;
	logic [2:0]       hidx;
	logic             terr_w;
	logic [7:0]       pay;
	logic             pay_valid;
	dmd_pkg::status_t status;

	// result register frees up when empty or when its word is taken
	assign advance = !out_valid_s2 || !out_stall;
	assign take    = item.valid && advance;
	assign b       = item.data;
	assign size_w  = {size_q[15:8], b};

	// next state
	always_comb begin
		phase_n   = phase_q;
		match_n   = match_q;
		size_n    = size_q;
		remain_n  = remain_q;
		type_n    = type_q;
		devtype_n = devtype_q;
		serial_n  = serial_q;
		terr_n    = terr_q;
		hidx      = 3'd0;
		terr_w    = terr_q;
		unique case (phase_q)
			dmd_pkg::PH_SIZE_HI: begin
				size_n  = {b, 8'h00};
				phase_n = dmd_pkg::PH_SIZE_LO;
			end
			dmd_pkg::PH_SIZE_LO: begin
				if (size_w < dmd_pkg::FRAME_OVERHEAD || size_w > max_frame_size) begin
					size_n  = 16'd0;
					phase_n = dmd_pkg::PH_HUNT;
					match_n = 3'd0;
				end else begin
					size_n   = size_w;
					remain_n = size_w - dmd_pkg::FRAME_OVERHEAD;
					phase_n  = dmd_pkg::PH_TYPE;
				end
			end
			dmd_pkg::PH_TYPE: begin
				type_n  = b;
				phase_n = dmd_pkg::PH_DEVTYPE;
			end
			dmd_pkg::PH_DEVTYPE: begin
				devtype_n = b;
				phase_n   = dmd_pkg::PH_SERIAL;
			end
			dmd_pkg::PH_SERIAL: begin
				serial_n = b;
				terr_n   = 1'b0;
				match_n  = 3'd0;
				phase_n  = (remain_q == 16'd0) ? dmd_pkg::PH_TAIL : dmd_pkg::PH_PAYLOAD;
			end
			dmd_pkg::PH_PAYLOAD: begin
				remain_n = remain_q - 16'd1;
				if (remain_n == 16'd0) begin
					match_n = 3'd0;
					phase_n = dmd_pkg::PH_TAIL;
				end
			end
			dmd_pkg::PH_TAIL: begin
				terr_w = terr_q || (match_q >= dmd_pkg::TAIL_LEN)
					|| (b != dmd_pkg::tail_byte(match_q));
				if (match_q >= dmd_pkg::TAIL_LAST) begin
					terr_n  = 1'b0;
					phase_n = dmd_pkg::PH_HUNT;
					match_n = 3'd0;
				end else begin
					terr_n  = terr_w;
					match_n = match_q + 3'd1;
				end
			end
			default: begin
				// header hunt; unused phase codes land here as well
				hidx    = (phase_q != dmd_pkg::PH_HUNT || match_q >= dmd_pkg::HDR_LEN)
					? 3'd0 : match_q;
				phase_n = dmd_pkg::PH_HUNT;
				if (b == dmd_pkg::hdr_byte(hidx)) begin
					if (hidx == dmd_pkg::HDR_LAST) begin
						match_n = 3'd0;
						phase_n = dmd_pkg::PH_SIZE_HI;
					end else begin
						match_n = hidx + 3'd1;
					end
				end else begin
					// a stray start byte still counts as the first header byte
					match_n = (b == dmd_pkg::BYTE_SOF) ? 3'd1 : 3'd0;
				end
			end
		endcase
	end

	// per-word outputs
	always_comb begin
		pay       = 8'h00;
		pay_valid = 1'b0;
		status    = dmd_pkg::ST_BUSY;
		unique case (phase_q)
			dmd_pkg::PH_SIZE_LO: begin
				if (size_w < dmd_pkg::FRAME_OVERHEAD || size_w > max_frame_size) begin
					status = dmd_pkg::ST_BAD_LEN;
				end
			end
			dmd_pkg::PH_PAYLOAD: begin
				pay       = b;
				pay_valid = 1'b1;
			end
			dmd_pkg::PH_TAIL: begin
				if (match_q >= dmd_pkg::TAIL_LAST) begin
					status = terr_w ? dmd_pkg::ST_BAD_TAIL : dmd_pkg::ST_GOOD;
				end
			end
			default: begin
				status = dmd_pkg::ST_BUSY;
			end
		endcase
	end

	// assemble the result word from the updated frame fields
	always_comb begin
		result_n.payload_byte   = pay;
		result_n.payload_valid  = pay_valid;
		result_n.message_type   = type_n;
		result_n.device_type    = devtype_n;
		result_n.device_serial  = serial_n;
		result_n.payload_length = (size_n >= dmd_pkg::FRAME_OVERHEAD)
			? size_n - dmd_pkg::FRAME_OVERHEAD : 16'd0;
		result_n.frame_status   = status;
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= dmd_pkg::PH_HUNT;
			match_q   <= 3'd0;
			size_q    <= 16'd0;
			remain_q  <= 16'd0;
			type_q    <= 8'h00;
			devtype_q <= 8'h00;
			serial_q  <= 8'h00;
			terr_q    <= 1'b0;
		end else if (take) begin
			phase_q   <= phase_n;
			match_q   <= match_n;
			size_q    <= size_n;
			remain_q  <= remain_n;
			type_q    <= type_n;
			devtype_q <= devtype_n;
			serial_q  <= serial_n;
			terr_q    <= terr_n;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= item.valid;
		end
	end

	// result data
	always_ff @(posedge clk) begin
		if (take) begin
			result_s2 <= result_n;
		end
	end

	assign out_valid = out_valid_s2;
	assign result    = result_s2;

endmodule

/* rtl/device_message_deframer.sv */
// device_message_deframer: top level, input register, frame parser and config register
// depends on dmd_pkg, dmd_in_stage, dmd_parser
//
// Byte-serial frame receiver. Each accepted word is one received byte and gives exactly
// one result word. A new byte can be taken every cycle, limited only by the result
// register, which holds one word while out_stall is high and frees up as soon as it is
// taken. The block hunts for the header 02 0D 0A, reads a big-endian total frame size
// (13 plus payload), then message type, device type and device serial, passes payload
// bytes through with payload_valid, and checks the tail 0D 0A 03 0D 0A, reporting good or
// bad tail on its last byte. A size below 13 or above max_frame_size reports a length
// error on the second size byte and returns to hunting. max_frame_size resets to 1024 and
// is written through cfg_wr_en/cfg_wr_data, by the user only while idle (not enforced).
module device_message_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  payload_byte,
	output logic        payload_valid,
	output logic [7:0]  message_type,
	output logic [7:0]  device_type,
	output logic [7:0]  device_serial,
	output logic [15:0] payload_length,
	output logic [1:0]  frame_status,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	logic [15:0]      max_frame_size_q;
	logic             advance;
	dmd_pkg::stage_t  item;
	dmd_pkg::result_t result;

	// max frame size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_size_q <= dmd_pkg::MAX_FRAME_RESET;
		end else if (cfg_wr_en) begin
			max_frame_size_q <= cfg_wr_data;
		end
	end

	dmd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.item     (item)
	);

	dmd_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item),
		.max_frame_size (max_frame_size_q),
		.out_stall      (out_stall),
		.advance        (advance),
		.out_valid      (out_valid),
		.result         (result)
	);

	// result fields
	assign payload_byte   = result.payload_byte;
	assign payload_valid  = result.payload_valid;
	assign message_type   = result.message_type;
	assign device_type    = result.device_type;
	assign device_serial  = result.device_serial;
	assign payload_length = result.payload_length;
	assign frame_status   = result.frame_status;

endmodule
